// ----- src/emg_naf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// EMG normalise and activation filter package
// Shared widths, constants, FSM state and control structs.
// ----------------------------------------------------------------------------
package emg_naf_pkg;

   localparam int SAMPLE_W = 16;
   localparam int CHAN_W   = 4;
   localparam int TAU_W    = 20;
   localparam int RATE_W   = 17;
   localparam int MEGA     = 1000000;
   localparam int K_W      = 57;   // fs*ta*td
   localparam int TM_W     = 40;   // ta*1e6
   localparam int ACC_W    = 90;   // divider dividend / shifted divisor

   localparam logic [15:0] ONE_Q15 = 16'h8000;

   localparam logic [1:0] REG_TAU_ACT   = 2'd0;
   localparam logic [1:0] REG_TAU_DEACT = 2'd1;
   localparam logic [1:0] REG_RATE      = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_NORM,
      ST_MUL1,
      ST_MUL2,
      ST_SUM1,
      ST_SUM2,
      ST_DIV,
      ST_DONE
   } state_type;

   // coefficients derived from the configuration (zero taken as one)
   typedef struct packed {
      logic [K_W-1:0]   k;
      logic [TM_W-1:0]  tm;
      logic [TAU_W-1:0] ta;
      logic [TAU_W-1:0] td;
   } coef_type;

   typedef struct packed {
      logic bnd_we;
      logic act_we;
   } mem_ctl_type;

endpackage
`default_nettype wire

// ----- src/emg_naf_csr.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// EMG filter configuration registers
// APB registers and a short product pipeline for the filter coefficients.
// ----------------------------------------------------------------------------
module emg_naf_csr (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [3:0]            csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic      [31:0]           csr_prdata,
   output logic                       csr_pready,
   output emg_naf_pkg::coef_type      coef
);

   logic [emg_naf_pkg::TAU_W-1:0]  ta_ff, td_ff;
   logic [emg_naf_pkg::RATE_W-1:0] fs_ff;
   logic [emg_naf_pkg::TAU_W-1:0]  ta_nz, td_nz;
   logic [emg_naf_pkg::RATE_W-1:0] fs_nz;
   logic [36:0]                    m1_ff, m1_in;
   logic [emg_naf_pkg::TM_W-1:0]   tm_ff, tm_in;
   logic [emg_naf_pkg::K_W-1:0]    k_ff, k_in;
   logic                           wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ta_ff <= 20'd10000;
         td_ff <= 20'd40000;
         fs_ff <= 17'd1000;
      end else if (wr_en) begin
         case (csr_paddr[3:2])
            emg_naf_pkg::REG_TAU_ACT:   ta_ff <= csr_pwdata[19:0];
            emg_naf_pkg::REG_TAU_DEACT: td_ff <= csr_pwdata[19:0];
            emg_naf_pkg::REG_RATE:      fs_ff <= csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         emg_naf_pkg::REG_TAU_ACT:   csr_prdata = {12'd0, ta_ff};
         emg_naf_pkg::REG_TAU_DEACT: csr_prdata = {12'd0, td_ff};
         emg_naf_pkg::REG_RATE:      csr_prdata = {15'd0, fs_ff};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   assign ta_nz = (ta_ff == '0) ? 20'd1 : ta_ff;
   assign td_nz = (td_ff == '0) ? 20'd1 : td_ff;
   assign fs_nz = (fs_ff == '0) ? 17'd1 : fs_ff;

   // two-stage products; settled long before the divider needs them
   assign m1_in = 37'(ta_nz) * 37'(fs_nz);
   assign tm_in = 40'(ta_nz) * 40'(emg_naf_pkg::MEGA);
   assign k_in  = 57'(m1_ff) * 57'(td_nz);

   always_ff @(posedge clock) begin
      m1_ff <= m1_in;
      tm_ff <= tm_in;
      k_ff  <= k_in;
   end

   assign coef.k  = k_ff;
   assign coef.tm = tm_ff;
   assign coef.ta = ta_nz;
   assign coef.td = td_nz;

endmodule
`default_nettype wire

// ----- src/emg_naf_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// EMG filter channel memories
// Bounds and activation stores, registered read, valid bits give reset zero.
// ----------------------------------------------------------------------------
module emg_naf_mem #(
   parameter int CHANNELS = 16,
   parameter int IDX_W    = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire emg_naf_pkg::mem_ctl_type  ctl,
   input  wire logic [IDX_W-1:0]          wr_idx,
   input  wire logic [IDX_W-1:0]          rd_idx,
   input  wire logic [15:0]               wr_offset,
   input  wire logic [15:0]               wr_scale,
   input  wire logic [15:0]               wr_act,
   output logic      [15:0]               rd_offset,
   output logic      [15:0]               rd_scale,
   output logic      [15:0]               rd_act
);

   logic [31:0]         bnd_mem [CHANNELS];
   logic [15:0]         act_mem [CHANNELS];
   logic [CHANNELS-1:0] bnd_valid_ff, act_valid_ff;
   logic [31:0]         bnd_rd_ff;
   logic [15:0]         act_rd_ff;
   logic                bnd_ok_ff, act_ok_ff;

   always_ff @(posedge clock) begin
      if (ctl.bnd_we) bnd_mem[wr_idx] <= {wr_scale, wr_offset};
      if (ctl.act_we) act_mem[wr_idx] <= wr_act;
      bnd_rd_ff <= bnd_mem[rd_idx];
      act_rd_ff <= act_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bnd_valid_ff <= '0;
         act_valid_ff <= '0;
         bnd_ok_ff    <= 1'b0;
         act_ok_ff    <= 1'b0;
      end else begin
         if (ctl.bnd_we) bnd_valid_ff[wr_idx] <= 1'b1;
         if (ctl.act_we) act_valid_ff[wr_idx] <= 1'b1;
         bnd_ok_ff <= bnd_valid_ff[rd_idx];
         act_ok_ff <= act_valid_ff[rd_idx];
      end
   end

   assign rd_offset = bnd_ok_ff ? bnd_rd_ff[15:0]  : 16'd0;
   assign rd_scale  = bnd_ok_ff ? bnd_rd_ff[31:16] : 16'd0;
   assign rd_act    = act_ok_ff ? act_rd_ff        : 16'd0;

endmodule
`default_nettype wire

// ----- src/emg_naf_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// EMG filter sequencer
// Normalising divider, coefficient products, activation divider, result reg.
// ----------------------------------------------------------------------------
module emg_naf_core #(
   parameter int CHANNELS    = 16,
   parameter int SAMPLE_BITS = 16,
   parameter int IDX_W       = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [55:0]               req_tdata,
   input  wire logic                      req_tuser,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic      [39:0]               rsp_tdata,
   input  wire emg_naf_pkg::coef_type     coef,
   output emg_naf_pkg::mem_ctl_type       mem_ctl,
   output logic      [IDX_W-1:0]          mem_wr_idx,
   output logic      [IDX_W-1:0]          mem_rd_idx,
   output logic      [15:0]               mem_wr_offset,
   output logic      [15:0]               mem_wr_scale,
   output logic      [15:0]               mem_wr_act,
   input  wire logic [15:0]               mem_rd_offset,
   input  wire logic [15:0]               mem_rd_scale,
   input  wire logic [15:0]               mem_rd_act
);

   localparam int AW = emg_naf_pkg::ACC_W;
   localparam logic [15:0] SMASK = (SAMPLE_BITS >= 16) ? 16'hFFFF :
                                   16'((32'd1 << SAMPLE_BITS) - 32'd1);

   emg_naf_pkg::state_type state_ff, state_in;

   logic [3:0]  req_ch;
   logic        accept, in_range, slot_free, norm_easy, norm_last;
   logic [3:0]  ch_ff;
   logic [15:0] raw_ff, scl_ff, nrem_ff, u_ff, p_ff, q_ff, act_sat;
   logic [3:0]  cnt_ff;
   logic [16:0] r1, r2, r1s, r2s;
   logic        b1, b2;
   logic [15:0] d_norm, nrem_nx, q_norm;
   logic [35:0] ud_ff, ua_ff;
   logic [47:0] pklo_ff;
   logic [40:0] pkhi_ff;
   logic [55:0] utd_ff, uta_ff;
   logic [72:0] pk_ff;
   logic [AW-1:0] num_ff, rem_ff, dsh_ff, den_sum;
   logic [57:0] dk_ff;
   logic [56:0] dd_ff;
   logic [73:0] nsum;
   logic        dfit;
   logic        out_valid_ff;
   logic [39:0] out_data_ff;

   assign req_ch    = req_tdata[3:0];
   assign req_tready = (state_ff == emg_naf_pkg::ST_IDLE);
   assign accept    = req_tvalid & req_tready;
   assign in_range  = (7'(req_ch) < 7'(CHANNELS));
   assign slot_free = ~out_valid_ff | rsp_tready;

   // normalisation special cases
   assign norm_easy = (raw_ff <= mem_rd_offset) | (mem_rd_scale == '0) |
                      ((raw_ff - mem_rd_offset) >= mem_rd_scale);
   assign d_norm    = raw_ff - mem_rd_offset;

   // two restoring steps per cycle; 16 quotient bits then dropped by one
   assign r1  = {nrem_ff, 1'b0};
   assign b1  = (r1 >= {1'b0, scl_ff});
   assign r1s = b1 ? (r1 - {1'b0, scl_ff}) : r1;
   assign r2  = {r1s[15:0], 1'b0};
   assign b2  = (r2 >= {1'b0, scl_ff});
   assign r2s = b2 ? (r2 - {1'b0, scl_ff}) : r2;
   assign nrem_nx   = r2s[15:0];
   assign q_norm    = {q_ff[13:0], b1, b2};
   assign norm_last = (cnt_ff == 4'd7);

   assign nsum    = 74'(utd_ff) + 74'(pk_ff);
   assign den_sum = AW'({dk_ff, 15'd0}) + {{(AW-57){dd_ff[56]}}, dd_ff};
   assign dfit    = (dsh_ff <= rem_ff);
   assign act_sat = (q_ff > emg_naf_pkg::ONE_Q15) ? emg_naf_pkg::ONE_Q15 : q_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         emg_naf_pkg::ST_IDLE:
            if (accept & in_range & ~req_tuser) state_in = emg_naf_pkg::ST_READ;
         emg_naf_pkg::ST_READ:
            state_in = norm_easy ? emg_naf_pkg::ST_MUL1 : emg_naf_pkg::ST_NORM;
         emg_naf_pkg::ST_NORM:
            if (norm_last) state_in = emg_naf_pkg::ST_MUL1;
         emg_naf_pkg::ST_MUL1: state_in = emg_naf_pkg::ST_MUL2;
         emg_naf_pkg::ST_MUL2: state_in = emg_naf_pkg::ST_SUM1;
         emg_naf_pkg::ST_SUM1: state_in = emg_naf_pkg::ST_SUM2;
         emg_naf_pkg::ST_SUM2: state_in = emg_naf_pkg::ST_DIV;
         emg_naf_pkg::ST_DIV:
            if (cnt_ff == '0) state_in = emg_naf_pkg::ST_DONE;
         emg_naf_pkg::ST_DONE:
            if (slot_free) state_in = emg_naf_pkg::ST_IDLE;
         default: state_in = emg_naf_pkg::ST_IDLE;
      endcase
   end

   // memory controls
   always_comb begin
      mem_ctl.bnd_we = accept & in_range & req_tuser;
      mem_ctl.act_we = (state_ff == emg_naf_pkg::ST_DONE) & slot_free;
      mem_wr_idx     = (state_ff == emg_naf_pkg::ST_DONE) ? IDX_W'(ch_ff) : IDX_W'(req_ch);
      mem_rd_idx     = IDX_W'(req_ch);
      mem_wr_offset  = req_tdata[35:20] & SMASK;
      mem_wr_scale   = req_tdata[51:36] & SMASK;
      mem_wr_act     = act_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= emg_naf_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         emg_naf_pkg::ST_IDLE: begin
            ch_ff  <= req_ch;
            raw_ff <= req_tdata[19:4] & SMASK;
         end
         emg_naf_pkg::ST_READ: begin
            p_ff    <= mem_rd_act;
            scl_ff  <= mem_rd_scale;
            nrem_ff <= d_norm;
            q_ff    <= '0;
            cnt_ff  <= '0;
            if (raw_ff <= mem_rd_offset) u_ff <= '0;
            else                         u_ff <= emg_naf_pkg::ONE_Q15;
         end
         emg_naf_pkg::ST_NORM: begin
            nrem_ff <= nrem_nx;
            q_ff    <= q_norm;
            cnt_ff  <= cnt_ff + 4'd1;
            if (norm_last) u_ff <= {1'b0, q_norm[15:1]};
         end
         emg_naf_pkg::ST_MUL1: begin
            ud_ff   <= 36'(u_ff) * 36'(coef.td);
            ua_ff   <= 36'(u_ff) * 36'(coef.ta);
            pklo_ff <= 48'(p_ff) * 48'(coef.k[31:0]);
            pkhi_ff <= 41'(p_ff) * 41'(coef.k[56:32]);
         end
         emg_naf_pkg::ST_MUL2: begin
            utd_ff <= 56'(ud_ff) * 56'(emg_naf_pkg::MEGA);
            uta_ff <= 56'(ua_ff) * 56'(emg_naf_pkg::MEGA);
            pk_ff  <= 73'(pklo_ff) + {pkhi_ff, 32'd0};
         end
         emg_naf_pkg::ST_SUM1: begin
            num_ff <= AW'({nsum, 15'd0});
            dk_ff  <= 58'(coef.k) + 58'(coef.tm);
            dd_ff  <= 57'(utd_ff) - 57'(uta_ff);
         end
         emg_naf_pkg::ST_SUM2: begin
            rem_ff <= num_ff;
            dsh_ff <= den_sum << 15;
            q_ff   <= '0;
            cnt_ff <= 4'd15;
         end
         emg_naf_pkg::ST_DIV: begin
            if (dfit) rem_ff <= rem_ff - dsh_ff;
            q_ff   <= {q_ff[14:0], dfit};
            dsh_ff <= dsh_ff >> 1;
            cnt_ff <= cnt_ff - 4'd1;
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if ((state_ff == emg_naf_pkg::ST_DONE) & slot_free) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == emg_naf_pkg::ST_DONE) & slot_free)
         out_data_ff <= {4'd0, act_sat, u_ff, ch_ff};
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
`default_nettype wire

// ----- src/emg_normalize_activation_filter_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// EMG normalise and activation filter
// Per-channel normalisation to Q1.15 followed by first-order nonlinear
// muscle activation dynamics, with per-channel state in on-chip memories.
// ----------------------------------------------------------------------------
// A sample request passes the read, normalise, MUL1, MUL2, SUM1, SUM2, divide
//   and done states; normalise is skipped when the normalised value is clamped.
// Throughput: one request at a time; the normaliser divides 2 bits a cycle
//   and the activation divider 1 bit a cycle.
// Bound-write requests and out-of-range channels do not leave the idle state.
// Reset: synchronous; registers return to 10000 us, 40000 us, 1000 Hz and
//   every channel's bounds and activation read as zero at once.
module emg_normalize_activation_filter_top #(
   parameter int CHANNELS    = 16,  // 1..16
   parameter int SAMPLE_BITS = 16   // 8..16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,  // channel[3:0] raw_sample[19:4]
                                        // bound_offset[35:20] bound_scale[51:36]
   input  wire logic        req_tuser,  // operation: 0 sample, 1 bound write
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [39:0] rsp_tdata,  // out_channel[3:0] normalized[19:4]
                                        // activation[35:20]
   // configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   // channel index width into the memories
   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   emg_naf_pkg::coef_type    coef;
   emg_naf_pkg::mem_ctl_type mem_ctl;
   logic [IDX_W-1:0]         mem_wr_idx, mem_rd_idx;
   logic [15:0]              mem_wr_offset, mem_wr_scale, mem_wr_act;
   logic [15:0]              mem_rd_offset, mem_rd_scale, mem_rd_act;

   // registers and coefficient products (fs*ta*td, ta*1e6)
   emg_naf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   // per-channel bounds and activation
   emg_naf_mem #(
      .CHANNELS (CHANNELS),
      .IDX_W    (IDX_W)
   ) u_mem (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mem_ctl),
      .wr_idx    (mem_wr_idx),
      .rd_idx    (mem_rd_idx),
      .wr_offset (mem_wr_offset),
      .wr_scale  (mem_wr_scale),
      .wr_act    (mem_wr_act),
      .rd_offset (mem_rd_offset),
      .rd_scale  (mem_rd_scale),
      .rd_act    (mem_rd_act)
   );

   // read, normalise, filter, write back; result held in an output register
   emg_naf_core #(
      .CHANNELS    (CHANNELS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .IDX_W       (IDX_W)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .coef          (coef),
      .mem_ctl       (mem_ctl),
      .mem_wr_idx    (mem_wr_idx),
      .mem_rd_idx    (mem_rd_idx),
      .mem_wr_offset (mem_wr_offset),
      .mem_wr_scale  (mem_wr_scale),
      .mem_wr_act    (mem_wr_act),
      .mem_rd_offset (mem_rd_offset),
      .mem_rd_scale  (mem_rd_scale),
      .mem_rd_act    (mem_rd_act)
   );

endmodule
`default_nettype wire

// ----- tb/emg_naf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EMG normalise and activation filter checker
// Watches the request, result and register ports. It keeps its own copy of
// the bounds, activation and register state, predicts every sample result
// and compares each delivered result against the oldest expectation.
// ----------------------------------------------------------------------------
module emg_naf_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [55:0] req_tdata,
   input  wire logic        req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   input  wire logic        csr_pready,
   output int               error_count,
   output int               pending_count,
   output int               result_count
);

   localparam logic OP_BOUND = 1'b1;

   // packed from the top bit down: activation, normalized, out_channel
   typedef struct packed {
      logic [15:0] act;
      logic [15:0] norm;
      logic [3:0]  chan;
   } emg_result_type;

   logic [emg_naf_pkg::TAU_W-1:0]  tau_act;
   logic [emg_naf_pkg::TAU_W-1:0]  tau_deact;
   logic [emg_naf_pkg::RATE_W-1:0] rate_hz;
   logic [15:0]       offset_mem [16];
   logic [15:0]       scale_mem  [16];
   logic [15:0]       act_mem    [16];
   emg_result_type    expected_results [$];

   function automatic logic [15:0] normalise(logic [15:0] raw, logic [15:0] off,
                                             logic [15:0] scl);
      logic [31:0] d;
      if (raw <= off) return 16'd0;
      if (scl == 0) return emg_naf_pkg::ONE_Q15;
      d = 32'(raw) - 32'(off);
      if (d >= 32'(scl)) return emg_naf_pkg::ONE_Q15;
      return 16'((d << 15) / 32'(scl));
   endfunction

   function automatic logic [15:0] filter_step(logic [15:0] u, logic [15:0] p);
      logic [127:0] ta, td, fs, mg, num, den, q;
      ta  = (tau_act == 0) ? 128'd1 : 128'(tau_act);
      td  = (tau_deact == 0) ? 128'd1 : 128'(tau_deact);
      fs  = (rate_hz == 0) ? 128'd1 : 128'(rate_hz);
      mg  = 128'(emg_naf_pkg::MEGA);
      num = (128'(u) * td * mg + 128'(p) * fs * ta * td) << 15;
      den = ((fs * ta * td + ta * mg) << 15) + 128'(u) * mg * td - 128'(u) * mg * ta;
      q   = num / den;
      return (q > 128'(emg_naf_pkg::ONE_Q15)) ? emg_naf_pkg::ONE_Q15 : q[15:0];
   endfunction

   task automatic report(string what, int got, int want);
      $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   initial begin
      error_count = 0;
      result_count = 0;
   end

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      emg_result_type r, e;
      logic [3:0]  ch;
      logic [15:0] u;
      if (reset) begin
         tau_act   <= 20'd10000;
         tau_deact <= 20'd40000;
         rate_hz   <= 17'd1000;
         for (int i = 0; i < 16; i++) begin
            offset_mem[i] <= '0;
            scale_mem[i]  <= '0;
            act_mem[i]    <= '0;
         end
         expected_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               emg_naf_pkg::REG_TAU_ACT:
                  tau_act   <= csr_pwdata[emg_naf_pkg::TAU_W-1:0];
               emg_naf_pkg::REG_TAU_DEACT:
                  tau_deact <= csr_pwdata[emg_naf_pkg::TAU_W-1:0];
               emg_naf_pkg::REG_RATE:
                  rate_hz   <= csr_pwdata[emg_naf_pkg::RATE_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            ch = req_tdata[3:0];
            if (req_tuser == OP_BOUND) begin
               offset_mem[ch] <= req_tdata[35:20];
               scale_mem[ch]  <= req_tdata[51:36];
            end else begin
               u      = normalise(req_tdata[19:4], offset_mem[ch], scale_mem[ch]);
               e.chan = ch;
               e.norm = u;
               e.act  = filter_step(u, act_mem[ch]);
               act_mem[ch] <= e.act;
               expected_results.push_back(e);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            r = rsp_tdata[35:0];
            result_count++;
            if (expected_results.size() == 0) begin
               report("unexpected result, channel", r.chan, -1);
            end else begin
               e = expected_results.pop_front();
               if (r.chan != e.chan) report("out_channel", r.chan, e.chan);
               if (r.norm != e.norm) report("normalized", r.norm, e.norm);
               if (r.act != e.act) report("activation", r.act, e.act);
            end
         end
      end
   end

endmodule

// ----- tb/emg_normalize_activation_filter_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EMG normalise and activation filter testbench
// Drives bound-write and sample requests with random gaps, stalls the result
// side at random and sweeps the time constants and sample rate, extremes
// included. Checking is done by the checker module beside the block.
// ----------------------------------------------------------------------------
module emg_normalize_activation_filter_top_test;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_BOUND  = 1'b1;
   localparam int   DRAIN_CYCLES = 40;   // longest sample latency plus margin

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;   // channel, raw_sample, bound_offset, bound_scale
   logic        req_tuser;   // operation
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // out_channel, normalized, activation
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int error_count, pending_count, result_count;
   int sample_reqs, bound_reqs, reg_writes;
   bit tb_done;

   emg_normalize_activation_filter_top dut (.*);

   emg_naf_checker checker_i (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_psel, .csr_penable,
      .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_pready,
      .error_count, .pending_count, .result_count
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // gap length: mostly short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // result side back-pressure; bursts of cycles with ready held high
   int  stall_left;
   int  calm_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
         calm_left  <= 0;
      end else if (calm_left > 0) begin
         calm_left  <= calm_left - 1;
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 199) == 0) begin
         calm_left  <= $urandom_range(100, 300);
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 2) != 0);
         stall_left <= pick_gap();
      end
   end

   // one request; valid stays high into the next one when there is no gap
   task automatic send_req(logic op, logic [3:0] ch, logic [15:0] raw,
                           logic [15:0] off, logic [15:0] scl);
      int gap;
      gap = pick_gap();
      if (gap > 0 && req_tvalid) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'd0, scl, off, raw, ch};
      do @(posedge clock); while (!req_tready);
      if (op == OP_BOUND) bound_reqs++;
      else sample_reqs++;
   endtask

   task automatic wait_idle();
      if (req_tvalid) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // APB write: setup then access, taken when psel/penable/pready all high
   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      reg_writes++;
   endtask

   task automatic set_regs(logic [31:0] ta, logic [31:0] td, logic [31:0] fs);
      write_reg(emg_naf_pkg::REG_TAU_ACT, ta);
      write_reg(emg_naf_pkg::REG_TAU_DEACT, td);
      write_reg(emg_naf_pkg::REG_RATE, fs);
   endtask

   // random mix: bound writes (about one in five) and samples with random raw values
   task automatic random_phase(int n);
      logic [3:0]  ch;
      logic [15:0] off, scl, raw;
      int sel;
      for (int i = 0; i < n; i++) begin
         ch  = 4'($urandom_range(0, 15));
         sel = $urandom_range(0, 9);
         if (sel < 2) begin
            off = 16'($urandom);
            case ($urandom_range(0, 3))
               0: scl = 16'd0;
               1: scl = 16'($urandom_range(1, 255));
               default: scl = 16'($urandom);
            endcase
            send_req(OP_BOUND, ch, 16'($urandom), off, scl);
         end else begin
            raw = 16'($urandom);
            send_req(OP_SAMPLE, ch, raw, 16'($urandom), 16'($urandom));
         end
      end
   endtask

   initial begin
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= OP_SAMPLE;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      reset       <= 1'b1;
      sample_reqs = 0;
      bound_reqs  = 0;
      reg_writes  = 0;
      tb_done     = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset bounds (zero scale), field extremes, clamps, mid values
      send_req(OP_SAMPLE, 4'd0, 16'd0, 16'd0, 16'd0);
      send_req(OP_SAMPLE, 4'd15, 16'hffff, 16'hffff, 16'hffff);
      send_req(OP_BOUND, 4'd3, 16'd0, 16'd1000, 16'd0);
      send_req(OP_SAMPLE, 4'd3, 16'd1000, 16'd0, 16'd0);      // raw equals offset
      send_req(OP_SAMPLE, 4'd3, 16'd1001, 16'd0, 16'd0);      // zero scale, above
      send_req(OP_BOUND, 4'd7, 16'hffff, 16'd100, 16'd2000);
      send_req(OP_SAMPLE, 4'd7, 16'd50, 16'd0, 16'd0);        // below offset
      send_req(OP_SAMPLE, 4'd7, 16'd1100, 16'd0, 16'd0);      // midway
      send_req(OP_SAMPLE, 4'd7, 16'd2100, 16'd0, 16'd0);      // d equals scale
      send_req(OP_SAMPLE, 4'd7, 16'hffff, 16'd0, 16'd0);      // saturating
      send_req(OP_BOUND, 4'd15, 16'd0, 16'hffff, 16'hffff);
      send_req(OP_SAMPLE, 4'd15, 16'hffff, 16'd0, 16'd0);
      send_req(OP_BOUND, 4'd0, 16'd0, 16'd0, 16'hffff);
      send_req(OP_SAMPLE, 4'd0, 16'hfffe, 16'd0, 16'd0);
      send_req(OP_SAMPLE, 4'd0, 16'd1, 16'd0, 16'd0);
      send_req(OP_BOUND, 4'd9, 16'd0, 16'd0, 16'd1);
      for (int i = 0; i < 5; i++) send_req(OP_SAMPLE, 4'd9, 16'd1, 16'd0, 16'd0);
      random_phase(80);
      wait_idle();   // sender holds off until every result is in

      // register sweep: extremes, zero taken as one, then random settings
      set_regs(1, 1, 1);
      random_phase(60);
      wait_idle();
      set_regs(1000000, 1000000, 100000);
      random_phase(60);
      wait_idle();
      set_regs(0, 0, 0);
      random_phase(40);
      wait_idle();
      set_regs(1, 1000000, 100000);
      random_phase(60);
      wait_idle();
      set_regs(1000000, 1, 1);
      random_phase(40);
      wait_idle();
      set_regs(32'hfffff, 32'hfffff, 32'h1ffff);
      random_phase(40);
      wait_idle();
      for (int k = 0; k < 3; k++) begin
         set_regs($urandom_range(1, 1000000), $urandom_range(1, 1000000),
                  $urandom_range(1, 100000));
         random_phase(40);
         wait_idle();
      end

      $display("covered %0d sample and %0d bound-write requests, %0d register writes",
               sample_reqs, bound_reqs, reg_writes);
      $display("%0d results checked with %0d mismatches", result_count, error_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      tb_done = 1;
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #4ms;
      if (!tb_done) begin
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule
